// File: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, codes and payload types for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Storage geometry
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Operation codes carried in the mode field
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [2:0] MODE_POP_BACK   = 3'd1;
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd2;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [2:0] MODE_REVERSE    = 3'd4;
  localparam logic [2:0] MODE_CLEAR      = 3'd5;

  // Result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Control sequencer
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } deq_state_t;

  // One request
  typedef struct packed {
    logic        [2:0]  mode;
    logic signed [31:0] value;
  } deq_req_t;

  // One result
  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] popped;
    logic        [6:0]  count;
  } deq_rsp_t;

endpackage

// File: rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed words in a ring buffer memory, with
// push and pop at either end, constant-time reverse and clear.
// ----------------------------------------------------------------------------
//  channel   | handshake                      | payload
//  ----------+--------------------------------+---------------------------
//  request   | start, taken when busy is low  | request (mode, value)
//  result    | result_valid, one-cycle strobe | result (status, popped, count)
//
//  A push, reverse, clear, unknown mode or failed pop gives its result in the
//  cycle after the request; the next request can be taken straight away.
//  A successful pop passes through ST_READ: busy stays high while the
//  synchronous memory read completes, and the result follows.
//  Reset is synchronous and clears pointers, count and direction; the memory
//  holds no reset value and needs no clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module double_ended_queue_top
  import deq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  deq_req_t request,
  output logic     result_valid,
  output deq_rsp_t result
);

  // Ring buffer storage
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [IDX_W-1:0]      mem_raddr;

  // Pointers and control
  deq_state_t       state, state_next;
  logic [IDX_W-1:0] back_index, back_index_next;
  logic [IDX_W-1:0] front_index, front_index_next;
  logic [CNT_W-1:0] occupancy, occupancy_next;
  logic             reversed, reversed_next;
  logic             result_valid_next;
  deq_rsp_t         result_next;

  logic             accept;
  logic             phys_back;
  logic [IDX_W-1:0] back_dec, front_dec, front_inc, back_inc;
  logic             is_full, is_empty;

  assign accept   = start && (state == ST_IDLE);
  assign busy     = (state != ST_IDLE);
  assign is_full  = (occupancy == CNT_W'(DEPTH));
  assign is_empty = (occupancy == '0);

  // Wrap the indices around the ring
  assign back_inc  = (back_index == IDX_W'(DEPTH - 1)) ? '0 : back_index + 1'b1;
  assign back_dec  = (back_index == '0) ? IDX_W'(DEPTH - 1) : back_index - 1'b1;
  assign front_inc = (front_index == IDX_W'(DEPTH - 1)) ? '0 : front_index + 1'b1;
  assign front_dec = (front_index == '0) ? IDX_W'(DEPTH - 1) : front_index - 1'b1;

  // Pick the physical end that serves the requested logical end
  always_comb begin
    case (request.mode) inside
      MODE_PUSH_BACK, MODE_POP_BACK: phys_back = !reversed;
      default:                       phys_back = reversed;
    endcase
  end

  // Decode the request, update pointers and steer the memory
  always_comb begin
    state_next        = state;
    back_index_next   = back_index;
    front_index_next  = front_index;
    occupancy_next    = occupancy;
    reversed_next     = reversed;
    result_valid_next = 1'b0;
    result_next       = result;
    mem_we            = 1'b0;
    mem_waddr         = back_index;
    mem_wdata         = DATA_WIDTH'(request.value);
    mem_re            = 1'b0;
    mem_raddr         = back_dec;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          result_valid_next  = 1'b1;
          result_next.status = STATUS_DONE;
          result_next.popped = '0;
          case (request.mode) inside
            MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
              if (is_full) begin
                result_next.status = STATUS_FULL;
              end else begin
                mem_we         = 1'b1;
                occupancy_next = occupancy + 1'b1;
                if (phys_back) begin
                  mem_waddr       = back_index;
                  back_index_next = back_inc;
                end else begin
                  mem_waddr        = front_dec;
                  front_index_next = front_dec;
                end
              end
            end
            MODE_POP_BACK, MODE_POP_FRONT: begin
              if (is_empty) begin
                result_next.status = STATUS_EMPTY;
              end else begin
                // Hold the result until the read data returns
                result_valid_next = 1'b0;
                mem_re            = 1'b1;
                occupancy_next    = occupancy - 1'b1;
                state_next        = ST_READ;
                if (phys_back) begin
                  mem_raddr       = back_dec;
                  back_index_next = back_dec;
                end else begin
                  mem_raddr        = front_index;
                  front_index_next = front_inc;
                end
              end
            end
            MODE_REVERSE: begin
              reversed_next = !reversed;
            end
            MODE_CLEAR: begin
              occupancy_next   = '0;
              back_index_next  = '0;
              front_index_next = '0;
              reversed_next    = 1'b0;
            end
            default: begin
              // Unknown modes leave the queue untouched
            end
          endcase
          result_next.count = 7'(occupancy_next);
        end
      end
      ST_READ: begin
        result_valid_next  = 1'b1;
        result_next.status = STATUS_DONE;
        result_next.popped = 32'($signed(rd_data));
        result_next.count  = 7'(occupancy);
        state_next         = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Write and read the ring buffer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      back_index   <= '0;
      front_index  <= '0;
      occupancy    <= '0;
      reversed     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      back_index   <= back_index_next;
      front_index  <= front_index_next;
      occupancy    <= occupancy_next;
      reversed     <= reversed_next;
      result_valid <= result_valid_next;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

// File: tb/double_ended_queue_top_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// Self-checking bench for the double-ended queue. A directed table covers the
// empty, full, reverse, clear and unused-mode cases, then bursts of random
// requests fill, drain and shuffle the queue. Every result is checked field
// by field against its table entry or an in-bench prediction of the ring buffer.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;
  import deq_pkg::*;

  // Mode codes that the block treats as no operation
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int N_RAND_REQ   = 1750;
  localparam int STALL_LIMIT  = 1000;
  localparam int N_ROWS       = 27;

  // One row of the directed table: a request repeated reps times (value
  // stepping by one), with an optional hand-written result
  typedef struct {
    logic        [2:0]  mode;
    logic signed [31:0] value;
    int                 reps;
    bit                 typed;
    deq_rsp_t           want;
  } step_row_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  deq_req_t request;
  logic     result_valid;
  deq_rsp_t result;

  // Predicted ring buffer state
  logic [DATA_WIDTH-1:0] slots [DEPTH];
  logic [IDX_W-1:0]      back_ptr;
  logic [IDX_W-1:0]      front_ptr;
  logic [CNT_W-1:0]      held;
  logic                  flipped;

  deq_rsp_t pending_rsp [$];
  bit       next_typed;
  deq_rsp_t next_want;
  int       errors;
  int       quiet_cycles;
  int       run_left;
  int       n_sent;

  step_row_t steps [N_ROWS] = '{
    '{MODE_POP_BACK,   32'sd0,         1,  1'b1, '{STATUS_EMPTY, 32'sd0, 7'd0}},
    '{MODE_POP_FRONT,  32'sd0,         1,  1'b1, '{STATUS_EMPTY, 32'sd0, 7'd0}},
    '{MODE_SPARE_LO,   32'h1234_5678,  1,  1'b1, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_SPARE_HI,   -32'sd1,        1,  1'b1, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_PUSH_BACK,  32'h7FFF_FFFF,  1,  1'b1, '{STATUS_DONE, 32'sd0, 7'd1}},
    '{MODE_PUSH_FRONT, 32'h8000_0000,  1,  1'b1, '{STATUS_DONE, 32'sd0, 7'd2}},
    '{MODE_POP_BACK,   32'sd0,         1,  1'b1, '{STATUS_DONE, 32'h7FFF_FFFF, 7'd1}},
    '{MODE_POP_FRONT,  32'sd0,         1,  1'b1, '{STATUS_DONE, 32'h8000_0000, 7'd0}},
    '{MODE_PUSH_BACK,  -32'sd1,        1,  1'b1, '{STATUS_DONE, 32'sd0, 7'd1}},
    '{MODE_PUSH_BACK,  32'sd0,         1,  1'b1, '{STATUS_DONE, 32'sd0, 7'd2}},
    '{MODE_REVERSE,    32'sd0,         1,  1'b1, '{STATUS_DONE, 32'sd0, 7'd2}},
    '{MODE_POP_BACK,   32'sd0,         1,  1'b0, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_PUSH_FRONT, 32'h5555_5555,  1,  1'b0, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_REVERSE,    32'sd0,         1,  1'b0, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_POP_FRONT,  32'sd0,         1,  1'b0, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_PUSH_BACK,  32'h0000_1000,  63, 1'b0, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_PUSH_BACK,  32'hAAAA_AAAA,  1,  1'b1, '{STATUS_FULL, 32'sd0, 7'd64}},
    '{MODE_PUSH_FRONT, 32'h5555_5555,  1,  1'b1, '{STATUS_FULL, 32'sd0, 7'd64}},
    '{MODE_REVERSE,    32'sd0,         1,  1'b0, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_POP_FRONT,  32'sd0,         64, 1'b0, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_POP_FRONT,  32'sd0,         1,  1'b1, '{STATUS_EMPTY, 32'sd0, 7'd0}},
    '{MODE_PUSH_FRONT, 32'hA5A5_A5A5,  1,  1'b0, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_REVERSE,    32'sd0,         1,  1'b0, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_CLEAR,      32'sd0,         1,  1'b1, '{STATUS_DONE, 32'sd0, 7'd0}},
    '{MODE_POP_BACK,   32'sd0,         1,  1'b1, '{STATUS_EMPTY, 32'sd0, 7'd0}},
    '{MODE_PUSH_BACK,  32'sd1,         1,  1'b1, '{STATUS_DONE, 32'sd0, 7'd1}},
    '{MODE_POP_FRONT,  32'sd0,         1,  1'b1, '{STATUS_DONE, 32'sd1, 7'd0}}
  };

  double_ended_queue_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  // Free-running clock, period 20
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [IDX_W-1:0] ptr_up(input logic [IDX_W-1:0] p);
    return (int'(p) + 1 >= DEPTH) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ptr_down(input logic [IDX_W-1:0] p);
    return (p == '0) ? IDX_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  // Apply one request to the predicted ring and return its result
  task automatic deque_predict(input deq_req_t rq, output deq_rsp_t rs);
    logic                  at_back;
    logic [DATA_WIDTH-1:0] word;
    rs = '{STATUS_DONE, 32'sd0, 7'd0};
    at_back = (rq.mode == MODE_PUSH_BACK || rq.mode == MODE_POP_BACK) ? !flipped : flipped;
    case (rq.mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          rs.status = STATUS_FULL;
        end else begin
          if (at_back) begin
            slots[back_ptr] = rq.value[DATA_WIDTH-1:0];
            back_ptr = ptr_up(back_ptr);
          end else begin
            front_ptr = ptr_down(front_ptr);
            slots[front_ptr] = rq.value[DATA_WIDTH-1:0];
          end
          held = held + 1'b1;
        end
      end
      MODE_POP_BACK, MODE_POP_FRONT: begin
        if (held == '0) begin
          rs.status = STATUS_EMPTY;
        end else begin
          if (at_back) begin
            back_ptr = ptr_down(back_ptr);
            word = slots[back_ptr];
          end else begin
            word = slots[front_ptr];
            front_ptr = ptr_up(front_ptr);
          end
          held = held - 1'b1;
          rs.popped = 32'(signed'(word));
        end
      end
      MODE_REVERSE: begin
        flipped = !flipped;
      end
      MODE_CLEAR: begin
        held      = '0;
        back_ptr  = '0;
        front_ptr = '0;
        flipped   = 1'b0;
      end
      default: begin
      end
    endcase
    rs.count = 7'(held);
  endtask

  // Check results, predict accepted requests and watch for a hang
  always @(posedge clk) begin
    deq_rsp_t want;
    deq_rsp_t model_rsp;
    if (!rst) begin
      if (result_valid) begin
        if (pending_rsp.size() == 0) begin
          $error("result with none expected: status %0d popped %0d count %0d",
                 result.status, result.popped, result.count);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            errors++;
          end
          if (result.popped !== want.popped) begin
            $error("popped: expected %0d, got %0d", want.popped, result.popped);
            errors++;
          end
          if (result.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, result.count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        deque_predict(request, model_rsp);
        pending_rsp.push_back(next_typed ? next_want : model_rsp);
      end
      if ((start && !busy) || result_valid) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Hold one request until the block takes it
  task automatic issue(input deq_req_t rq, input bit typed, input deq_rsp_t want);
    @(negedge clk);
    start      <= 1'b1;
    request    <= rq;
    next_typed  = typed;
    next_want   = want;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  // Insert a random gap once the current burst runs out
  task automatic pace();
    int gap;
    if (run_left > 0) begin
      run_left--;
    end else begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        start   <= 1'b0;
        request <= '{mode: 3'($urandom), value: $urandom};
      end
      run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 12);
    end
  endtask

  // Hold off until every outstanding result has arrived
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  function automatic deq_req_t mixed_request();
    deq_req_t rq;
    int       r;
    r = $urandom_range(0, 99);
    rq.value = $urandom;
    if (r < 22)       rq.mode = MODE_PUSH_BACK;
    else if (r < 44)  rq.mode = MODE_PUSH_FRONT;
    else if (r < 62)  rq.mode = MODE_POP_BACK;
    else if (r < 80)  rq.mode = MODE_POP_FRONT;
    else if (r < 89)  rq.mode = MODE_REVERSE;
    else if (r < 92)  rq.mode = MODE_CLEAR;
    else if (r < 96)  rq.mode = MODE_SPARE_LO;
    else              rq.mode = MODE_SPARE_HI;
    return rq;
  endfunction

  initial begin
    deq_req_t rq;
    deq_rsp_t none;
    int       kind;
    int       len;
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    next_typed   = 1'b0;
    next_want    = '0;
    none         = '0;
    errors       = 0;
    quiet_cycles = 0;
    run_left     = 0;
    n_sent       = 0;
    back_ptr     = '0;
    front_ptr    = '0;
    held         = '0;
    flipped      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (steps[i]) begin
      for (int k = 0; k < steps[i].reps; k++) begin
        rq.mode  = steps[i].mode;
        rq.value = steps[i].value + k;
        issue(rq, steps[i].typed, steps[i].want);
        pace();
      end
    end
    settle();

    // Random bursts: fill to overflow, drain past empty, or a free mix
    while (n_sent < N_RAND_REQ) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        len = DEPTH + $urandom_range(1, 4);
        repeat (len) begin
          rq.value = $urandom;
          rq.mode  = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
          issue(rq, 1'b0, none);
          pace();
        end
      end else if (kind < 4) begin
        len = DEPTH + $urandom_range(1, 4);
        repeat (len) begin
          rq.value = $urandom;
          rq.mode  = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
          if ($urandom_range(0, 15) == 0) rq.mode = MODE_REVERSE;
          issue(rq, 1'b0, none);
          pace();
        end
      end else begin
        len = $urandom_range(1, 40);
        repeat (len) begin
          issue(mixed_request(), 1'b0, none);
          pace();
        end
      end
      if ($urandom_range(0, 7) == 0) settle();
    end

    // Drain and let the pipeline go quiet
    @(negedge clk);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
